[hw/rtl/assert_macros.svh]
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property that must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition that must never be seen out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

[hw/rtl/npcs_pkg.sv]
// types, constants and palette table of the nearest palette color search
`timescale 1ns / 1ps
package npcs_pkg;

  localparam int unsigned PAL_DEPTH = 128;
  localparam int unsigned IDX_W     = 7;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned SQ_W      = 16;
  localparam int unsigned DIST_W    = 18;

  localparam logic [DIST_W-1:0] START_DIST = DIST_W'(255 * 255 * 3);
  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(PAL_DEPTH - 1);
  localparam logic [CHAN_W-1:0] LVL_MAX    = 8'd255;
  localparam logic [CHAN_W-1:0] HIGH_BASE  = 8'd127;
  localparam logic [3:0]        HIGH_STEPS = 4'd8;
  localparam logic [2:0]        HIGH_GRP   = 3'd6;

  // channel mask per group: bit 0 red, bit 1 green, bit 2 blue
  localparam logic [2:0] GROUP_CHAN [8] = '{3'b001, 3'b011, 3'b010, 3'b110,
                                            3'b100, 3'b101, 3'b001, 3'b111};

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pal_entry_t;

  // tag that travels with each palette entry down the pipeline
  typedef struct packed {
    logic             vld;
    logic             last;
    logic [IDX_W-1:0] idx;
  } tag_t;

  // palette color of one index
  function automatic pal_entry_t pal_entry(input logic [IDX_W-1:0] idx);
    logic [2:0]        grp;
    logic [3:0]        step;
    logic [CHAN_W-1:0] lvl;
    logic [2:0]        chan;
    pal_entry_t        e;
    grp  = idx[6:4];
    step = idx[3:0];
    if (grp < HIGH_GRP) begin
      // step zero would be -1, taken as black
      lvl = (step == 4'd0) ? '0 : {step - 4'd1, 4'hF};
    end else begin
      // bright levels saturate at full scale
      lvl = (step > HIGH_STEPS) ? LVL_MAX : {step, 4'h0} + HIGH_BASE;
    end
    chan    = GROUP_CHAN[grp];
    e.red   = chan[0] ? lvl : '0;
    e.green = chan[1] ? lvl : '0;
    e.blue  = chan[2] ? lvl : '0;
    return e;
  endfunction

endpackage

[hw/rtl/npcs_palette.sv]
// palette table with a registered read port
`timescale 1ns / 1ps
module npcs_palette
  import npcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tag_t       tag_i,
  output tag_t       tag_o,
  output pal_entry_t entry_o
);

  tag_t       tag_q;
  pal_entry_t entry_q;

  // read data register
  always_ff @(posedge clk_i) begin
    entry_q <= pal_entry(tag_i.idx);
  end

  // tag follows the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  assign tag_o   = tag_q;
  assign entry_o = entry_q;

endmodule

[hw/rtl/npcs_dist.sv]
// squared distance between the color and one palette entry, two stages
`timescale 1ns / 1ps
module npcs_dist
  import npcs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tag_t              tag_i,
  input  pal_entry_t        entry_i,
  input  logic [CHAN_W-1:0] red_i,
  input  logic [CHAN_W-1:0] green_i,
  input  logic [CHAN_W-1:0] blue_i,
  output tag_t              tag_o,
  output logic [DIST_W-1:0] dist_o
);

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
    logic [SQ_W-1:0] d;
    d = SQ_W'((a > b) ? a - b : b - a);
    return d * d;
  endfunction

  tag_t              sq_tag_q;
  tag_t              sum_tag_q;
  logic [SQ_W-1:0]   sq_r_q;
  logic [SQ_W-1:0]   sq_g_q;
  logic [SQ_W-1:0]   sq_b_q;
  logic [DIST_W-1:0] sum_q;

  // per channel squares
  always_ff @(posedge clk_i) begin
    sq_r_q <= sq_diff(entry_i.red, red_i);
    sq_g_q <= sq_diff(entry_i.green, green_i);
    sq_b_q <= sq_diff(entry_i.blue, blue_i);
  end

  // sum of the squares
  always_ff @(posedge clk_i) begin
    sum_q <= DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);
  end

  // tags for both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_tag_q  <= '0;
      sum_tag_q <= '0;
    end else begin
      sq_tag_q  <= tag_i;
      sum_tag_q <= sq_tag_q;
    end
  end

  assign tag_o  = sum_tag_q;
  assign dist_o = sum_q;

endmodule

[hw/rtl/nearest_palette_color_search.sv]
// top level of the nearest palette color search
`timescale 1ns / 1ps
// Finds the index of the nearest of 128 fixed palette colors to an RGB color,
// by squared Euclidean distance, lowest index on a tie.
// Input: a word (red_i, green_i, blue_i) is taken at a rising edge with start
// high and busy low. busy stays high until done_o rises.
// Output: palette_index_o is valid for exactly one cycle, marked by done_o;
// the receiver cannot stall, so the result is taken in that cycle.
// Sequence: the address counter walks the palette table one entry per cycle,
// then the table read, square and sum stages and the compare feed the result
// register; done_o rises at the same edge at which busy drops, so a new word
// can be taken at the edge that ends the done_o cycle.
// Words do not overlap: a new word is taken only after the last result, since
// the single distance datapath is shared by all palette entries.
// Reset: asynchronous, active low; the block comes up idle with busy low
// and done_o low.
module nearest_palette_color_search
  import npcs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [CHAN_W-1:0] red_i,
  input  logic [CHAN_W-1:0] green_i,
  input  logic [CHAN_W-1:0] blue_i,
  output logic              done_o,
  output logic [IDX_W-1:0]  palette_index_o
);

`include "assert_macros.svh"

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [IDX_W-1:0]  idx_q;
  logic [CHAN_W-1:0] red_q, green_q, blue_q;
  logic [DIST_W-1:0] best_dist_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic              done_q;
  logic [IDX_W-1:0]  index_q;
  logic              accept;
  logic              win;
  tag_t              issue_tag;
  tag_t              rd_tag;
  tag_t              cmp_tag;
  pal_entry_t        rd_entry;
  logic [DIST_W-1:0] cmp_dist;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  // address issue
  assign issue_tag.vld  = (state_q == ST_SCAN);
  assign issue_tag.last = (idx_q == LAST_IDX);
  assign issue_tag.idx  = idx_q;

  npcs_palette u_palette (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (issue_tag),
    .tag_o   (rd_tag),
    .entry_o (rd_entry)
  );

  npcs_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (rd_tag),
    .entry_i (rd_entry),
    .red_i   (red_q),
    .green_i (green_q),
    .blue_i  (blue_q),
    .tag_o   (cmp_tag),
    .dist_o  (cmp_dist)
  );

  // strictly smaller wins, keeps the lowest index on a tie
  assign win = cmp_dist < best_dist_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (idx_q == LAST_IDX) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (cmp_tag.vld && cmp_tag.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmp_tag.vld && cmp_tag.last;
      if (accept) begin
        idx_q <= '0;
      end else if (state_q == ST_SCAN) begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  // input word capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
    end
  end

  // running best and result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      best_dist_q <= START_DIST;
      best_idx_q  <= '0;
    end else if (cmp_tag.vld && win) begin
      best_dist_q <= cmp_dist;
      best_idx_q  <= cmp_tag.idx;
    end
    if (cmp_tag.vld && cmp_tag.last) begin
      index_q <= win ? cmp_tag.idx : best_idx_q;
    end
  end

  assign done_o          = done_q;
  assign palette_index_o = index_q;

  // checks
  `ASSERT_PROP(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
  `ASSERT_PROP(a_done_idle, done_o |-> !busy, "result shown while still busy")
  `ASSERT_PROP(a_done_pulse, done_o |=> !done_o, "result strobe longer than one cycle")
  `ASSERT_NEVER(a_tag_idle, cmp_tag.vld && !busy, "pipeline entry while idle")

endmodule
